// ----- rtl/radix_address_map_defines.svh -----
// Assertion macros for the radix address map.
// Included by modules that assert; no other dependencies.
`ifndef RADIX_ADDRESS_MAP_DEFINES_SVH
`define RADIX_ADDRESS_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define RAM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ram_pkg.sv -----
// Package for the radix address map: sizes, key fields, controller commands.
// No dependencies.
`timescale 1ns / 1ps
package ram_pkg;
    localparam int UPPER_ENTRIES = 16;
    localparam int MIDDLE_NODES  = 64;
    localparam int LEAF_GROUPS   = 256;
    localparam int LEAF_ENTRIES  = 4096;
    localparam int SLOTS         = 32;
    localparam int UW = $clog2(UPPER_ENTRIES + 1);  // count widths
    localparam int MW = $clog2(MIDDLE_NODES + 1);
    localparam int GW = $clog2(LEAF_GROUPS + 1);
    localparam int LW = $clog2(LEAF_ENTRIES + 1);
    localparam int UI = (UPPER_ENTRIES > 1) ? $clog2(UPPER_ENTRIES) : 1;
    localparam int MI = (MIDDLE_NODES > 1) ? $clog2(MIDDLE_NODES) : 1;
    localparam int GI = (LEAF_GROUPS > 1) ? $clog2(LEAF_GROUPS) : 1;
    localparam int LI = (LEAF_ENTRIES > 1) ? $clog2(LEAF_ENTRIES) : 1;
    localparam int SI = MI + 5;                     // slot table address
    localparam int SLOT_DEPTH = MIDDLE_NODES * SLOTS;

    // controller to datapath commands
    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_CLR, CMD_SCAN_U, CMD_SCAN_M, CMD_READ_S,
        CMD_SCAN_L, CMD_COMMIT, CMD_RD_VAL
    } cmd_t;

    typedef struct packed {
        logic clr_done;   // slot clear pass finished
        logic scan_done;  // current scan finished
        logic hit;        // current level hit
        logic full;       // insert would overflow a pool
    } stat_t;
endpackage

// ----- rtl/radix_address_map.sv -----
// Top level of the radix address map: controller plus datapath.
// Depends on ram_pkg, ram_ctrl, ram_datapath.
//   channel  dir  tdata fields (low bit up)          tuser
//   s_axis   in   key[63:0], value[127:64]           kind
//   m_axis   out  result_data[63:0]                  {status[1], found[0]}
// One beat at a time. For a find or an insert, the scans cover the used counts in
// the upper, middle and leaf lists (one stored entry read per cycle from single-port
// memories; a hit ends a scan early and a missed level skips the scans below it);
// leaf scans dominate. After reset the slot table of MIDDLE_NODES*32 = 2048 entries
// is cleared with s_tready low. A stalled result holds until m_tready.
`timescale 1ns / 1ps
module radix_address_map (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // key, value
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_data
    output logic [1:0]   m_tuser    // found, status
);
    import ram_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  found, status;

    ram_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .kind(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    ram_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_key(s_tdata[63:0]), .in_value(s_tdata[127:64]), .stat(stat),
        .res_found(found), .res_data(m_tdata), .res_status(status)
    );

    assign m_tuser = {status, found};
endmodule

// ----- rtl/ram_datapath.sv -----
// Datapath: level stores, scanning counters, slot table with clear pass.
// Depends on ram_pkg and radix_address_map_defines.svh.
`timescale 1ns / 1ps
`include "radix_address_map_defines.svh"
module ram_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ram_pkg::cmd_t     cmd,
    input  logic [63:0]       in_key,
    input  logic [63:0]       in_value,
    output ram_pkg::stat_t    stat,
    output logic              res_found,
    output logic [63:0]       res_data,
    output logic              res_status
);
    import ram_pkg::*;

    // memories
    logic [31:0]     upper_mem [UPPER_ENTRIES];
    logic [UI+15:0]  middle_mem [MIDDLE_NODES];
    logic [GI:0]     slot_mem [SLOT_DEPTH];
    logic [GI+7:0]   ltag_mem [LEAF_ENTRIES];
    logic [63:0]     lval_mem [LEAF_ENTRIES];

    logic [63:0]     key_reg, value_reg;
    logic [UW-1:0]   ucnt_reg;
    logic [MW-1:0]   mcnt_reg;
    logic [GW-1:0]   gcnt_reg;
    logic [LW-1:0]   lcnt_reg;
    logic [LW-1:0]   idx_reg;     // scan position, shared by all levels
    logic [SI:0]     clr_reg;
    logic            clr_busy_reg;
    logic            hu_reg, hm_reg, hg_reg, hl_reg;
    logic [UI-1:0]   u_reg;
    logic [MI-1:0]   m_reg;
    logic [GI-1:0]   g_reg;
    logic [LI-1:0]   l_reg;
    logic [31:0]     urd_reg;
    logic [UI+15:0]  mrd_reg;
    logic [GI+7:0]   lrd_reg;
    logic [GI:0]     srd_reg;
    logic [63:0]     vrd_reg;
    logic            rdv_reg;     // read data of the previous scan step valid
    logic [LW-1:0]   ridx_reg;    // index that read data belongs to
    logic            found_reg, status_reg;
    logic [63:0]     data_reg;

    logic [15:0]     k_mid;
    logic [4:0]      k_slot;
    logic [7:0]      k_lo;
    logic [SI-1:0]   saddr;
    logic            full;
    logic [LW-1:0]   lim;
    logic            cmp;
    logic [UI-1:0]   nu;
    logic [MI-1:0]   nm;
    logic [GI-1:0]   ng;
    logic [LI-1:0]   nl;

    assign k_mid  = key_reg[31:16];
    assign k_slot = key_reg[15:11];
    assign k_lo   = key_reg[10:3];
    assign saddr  = {m_reg, k_slot};

    // new indexes when creating
    assign nu = hu_reg ? u_reg : ucnt_reg[UI-1:0];
    assign nm = hm_reg ? m_reg : mcnt_reg[MI-1:0];
    assign ng = hg_reg ? g_reg : gcnt_reg[GI-1:0];
    assign nl = hl_reg ? l_reg : lcnt_reg[LI-1:0];

    assign full = (!hu_reg && ucnt_reg >= UW'(UPPER_ENTRIES))
               || (!hm_reg && mcnt_reg >= MW'(MIDDLE_NODES))
               || (!hg_reg && gcnt_reg >= GW'(LEAF_GROUPS))
               || (!hl_reg && lcnt_reg >= LW'(LEAF_ENTRIES));

    // scan limit and compare of the word read last cycle
    always_comb
    begin
        lim = '0;
        cmp = 1'b0;
        unique case (cmd)
            CMD_SCAN_U:
            begin
                lim = LW'(ucnt_reg);
                cmp = (urd_reg == key_reg[63:32]);
            end
            CMD_SCAN_M:
            begin
                lim = LW'(mcnt_reg);
                cmp = (mrd_reg == {u_reg, k_mid});
            end
            CMD_SCAN_L:
            begin
                lim = lcnt_reg;
                cmp = (lrd_reg == {g_reg, k_lo});
            end
            default: ;
        endcase
    end

    // leaf scan ends at once when the slot points at no group
    assign stat.clr_done  = !clr_busy_reg;
    assign stat.scan_done = (cmd == CMD_SCAN_U) ? (hu_reg || (!rdv_reg && idx_reg >= lim)) :
                            (cmd == CMD_SCAN_M) ? (hm_reg || (!rdv_reg && idx_reg >= lim)) :
                            (hl_reg || !hg_reg || (!rdv_reg && idx_reg >= lim));
    assign stat.hit  = (cmd == CMD_SCAN_U) ? hu_reg : (cmd == CMD_SCAN_M) ? hm_reg :
                       (cmd == CMD_READ_S) ? hg_reg : hl_reg;
    assign stat.full = full;

    // memory ports
    always_ff @(posedge clk)
    begin
        urd_reg <= upper_mem[idx_reg[UI-1:0]];
        mrd_reg <= middle_mem[idx_reg[MI-1:0]];
        lrd_reg <= ltag_mem[idx_reg[LI-1:0]];
        srd_reg <= slot_mem[saddr];
        vrd_reg <= lval_mem[l_reg];
        if (clr_busy_reg)
            slot_mem[clr_reg[SI-1:0]] <= '0;
        else if (cmd == CMD_COMMIT && !full && !hg_reg)
            slot_mem[{nm, k_slot}] <= {1'b1, ng};
        if (cmd == CMD_COMMIT && !full)
        begin
            if (!hu_reg) upper_mem[nu] <= key_reg[63:32];
            if (!hm_reg) middle_mem[nm] <= {nu, k_mid};
            if (!hl_reg) ltag_mem[nl] <= {ng, k_lo};
            lval_mem[nl] <= value_reg;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            key_reg   <= in_key;
            value_reg <= in_value;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ucnt_reg <= '0; mcnt_reg <= '0; gcnt_reg <= '0; lcnt_reg <= '0;
            idx_reg <= '0; ridx_reg <= '0; rdv_reg <= 1'b0;
            clr_reg <= '0; clr_busy_reg <= 1'b1;
            hu_reg <= 1'b0; hm_reg <= 1'b0; hg_reg <= 1'b0; hl_reg <= 1'b0;
            u_reg <= '0; m_reg <= '0; g_reg <= '0; l_reg <= '0;
            found_reg <= 1'b0; status_reg <= 1'b0; data_reg <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == (SI+1)'(SLOT_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            unique case (cmd)
                CMD_LOAD:
                begin
                    hu_reg <= 1'b0; hm_reg <= 1'b0; hg_reg <= 1'b0; hl_reg <= 1'b0;
                    idx_reg <= '0; rdv_reg <= 1'b0;
                end
                CMD_SCAN_U, CMD_SCAN_M, CMD_SCAN_L:
                begin
                    if (rdv_reg && cmp)
                    begin
                        if (cmd == CMD_SCAN_U) begin hu_reg <= 1'b1; u_reg <= ridx_reg[UI-1:0]; end
                        if (cmd == CMD_SCAN_M) begin hm_reg <= 1'b1; m_reg <= ridx_reg[MI-1:0]; end
                        if (cmd == CMD_SCAN_L) begin hl_reg <= 1'b1; l_reg <= ridx_reg[LI-1:0]; end
                    end
                    if (stat.scan_done || (rdv_reg && cmp))
                    begin
                        idx_reg <= '0;
                        rdv_reg <= 1'b0;
                    end
                    else if (idx_reg < lim)
                    begin
                        ridx_reg <= idx_reg;
                        idx_reg  <= idx_reg + 1'b1;
                        rdv_reg  <= 1'b1;
                    end
                    else
                        rdv_reg <= 1'b0;
                end
                CMD_READ_S:
                begin
                    hg_reg <= srd_reg[GI];
                    g_reg  <= srd_reg[GI-1:0];
                end
                CMD_COMMIT:
                begin
                    found_reg <= 1'b0;
                    data_reg <= '0;
                    status_reg <= full;
                    if (!full)
                    begin
                        if (!hu_reg) ucnt_reg <= ucnt_reg + 1'b1;
                        if (!hm_reg) mcnt_reg <= mcnt_reg + 1'b1;
                        if (!hg_reg) gcnt_reg <= gcnt_reg + 1'b1;
                        if (!hl_reg) lcnt_reg <= lcnt_reg + 1'b1;
                    end
                end
                CMD_RD_VAL:
                begin
                    status_reg <= 1'b0;
                    found_reg <= hl_reg;
                    data_reg <= hl_reg ? vrd_reg : 64'd0;
                end
                default: ;
            endcase
        end
    end

    assign res_found  = found_reg;
    assign res_data   = data_reg;
    assign res_status = status_reg;

    `RAM_ASSERT_IMPL(a_ucnt, clk, rst_n, 1'b1, ucnt_reg <= UW'(UPPER_ENTRIES))
    `RAM_ASSERT_IMPL(a_lcnt, clk, rst_n, 1'b1, lcnt_reg <= LW'(LEAF_ENTRIES))
    `RAM_ASSERT_NEXT(a_full, clk, rst_n, cmd == CMD_COMMIT && full, $stable(lcnt_reg))
    `RAM_ASSERT_IMPL(a_chain, clk, rst_n, hl_reg, hg_reg && hm_reg && hu_reg)
endmodule

// ----- rtl/ram_ctrl.sv -----
// Controller: sequences one beat through the four level lookups.
// Depends on ram_pkg and radix_address_map_defines.svh.
`timescale 1ns / 1ps
`include "radix_address_map_defines.svh"
module ram_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           kind,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  ram_pkg::stat_t stat,
    output ram_pkg::cmd_t  cmd
);
    import ram_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SU, S_SM, S_RS0, S_RS1, S_SL, S_FIN, S_RV0, S_RV1, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ins_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (stat.clr_done) state_next = S_IDLE;
            S_IDLE: if (s_tvalid) begin cmd = CMD_LOAD; state_next = S_SU; end
            S_SU:
            begin
                cmd = CMD_SCAN_U;
                if (stat.scan_done) state_next = stat.hit ? S_SM : S_FIN;
            end
            S_SM:
            begin
                cmd = CMD_SCAN_M;
                if (stat.scan_done) state_next = stat.hit ? S_RS0 : S_FIN;
            end
            S_RS0:  state_next = S_RS1;  // slot read latency
            S_RS1:  begin cmd = CMD_READ_S; state_next = S_SL; end
            S_SL:
            begin
                // ends at once when the slot holds no group
                cmd = CMD_SCAN_L;
                if (stat.scan_done) state_next = S_FIN;
            end
            S_FIN:  state_next = ins_reg ? S_OUT : S_RV0;
            S_RV0:  state_next = S_RV1;   // value read latency
            S_RV1:  begin cmd = CMD_RD_VAL; state_next = S_OUT; end
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_FIN && ins_reg) cmd = CMD_COMMIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ins_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) ins_reg <= kind;
        end
    end

    `RAM_ASSERT_IMPL(a_excl, clk, rst_n, 1'b1, !(s_tready && m_tvalid))
    `RAM_ASSERT_NEXT(a_out, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `RAM_ASSERT_NEXT(a_start, clk, rst_n, s_tvalid && s_tready, state_reg == S_SU)
endmodule
